[rtl/core/mabc_pkg.sv]
package mabc_pkg;

	localparam int MAX_DIM = 8192;

	localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [2:0] REG_CANVAS_WIDTH   = 3'd2;
	localparam logic [2:0] REG_CANVAS_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_SKIP_THRESHOLD = 3'd4;

	localparam logic [16:0] MASK_FULL     = 17'd65536;
	localparam logic [16:0] THRESHOLD_RST = 17'd65;
	localparam logic [15:0] RECIP_255     = 16'h8081;

	typedef struct packed {
		logic signed [14:0] origin_x;
		logic signed [14:0] origin_y;
		logic [13:0]        width;
		logic [13:0]        height;
		logic [16:0]        thr;
		logic [24:0]        thr255;
	} cfg_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	function automatic logic [13:0] sat_dim(input logic [13:0] v);
		logic [13:0] lim;
		lim = 14'(MAX_DIM);
		return (v > lim) ? lim : v;
	endfunction

endpackage

[rtl/core/mabc_cfg.sv]
module mabc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output mabc_pkg::cfg_t     cfg
);

	mabc_pkg::cfg_t cfg_q;
	logic           wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.width    <= '0;
			cfg_q.height   <= '0;
			cfg_q.thr      <= mabc_pkg::THRESHOLD_RST;
			cfg_q.thr255   <= 25'({8'd0, mabc_pkg::THRESHOLD_RST} * 25'd255);
		end else if (wr) begin
			case (cfg_index)
				mabc_pkg::REG_ORIGIN_X: begin
					cfg_q.origin_x <= $signed(cfg_data[14:0]);
				end
				mabc_pkg::REG_ORIGIN_Y: begin
					cfg_q.origin_y <= $signed(cfg_data[14:0]);
				end
				mabc_pkg::REG_CANVAS_WIDTH: begin
					cfg_q.width <= mabc_pkg::sat_dim(cfg_data[13:0]);
				end
				mabc_pkg::REG_CANVAS_HEIGHT: begin
					cfg_q.height <= mabc_pkg::sat_dim(cfg_data[13:0]);
				end
				mabc_pkg::REG_SKIP_THRESHOLD: begin
					cfg_q.thr    <= cfg_data[16:0];
					cfg_q.thr255 <= {cfg_data[16:0], 8'd0} - {8'd0, cfg_data[16:0]};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/mabc_lerp.sv]
module mabc_lerp (
	input  logic                  clk,
	input  mabc_pkg::stage_en_t   en,
	input  logic [23:0]           n_s1,
	input  logic [7:0]            canvas_s1,
	input  logic [7:0]            frag_s1,
	input  logic                  keep_s3,
	output logic [7:0]            res_s4
);

	logic signed [33:0] p_s2;
	logic [7:0]         c_s2;
	logic [15:0]        q_s3;
	logic signed [8:0]  diff;
	logic signed [33:0] prod;
	logic [31:0]        base;
	logic signed [33:0] num;
	logic [31:0]        recip;

	// Blend as canvas*D + N*(frag - canvas), then divide by D = 255 * 65536.
	assign diff  = $signed({1'b0, frag_s1}) - $signed({1'b0, canvas_s1});
	assign prod  = $signed({1'b0, n_s1}) * 34'(diff);
	assign base  = {({c_s2, 8'd0} - {8'd0, c_s2}), 16'd0};
	assign num   = $signed({2'b00, base}) + p_s2;
	assign recip = q_s3 * mabc_pkg::RECIP_255;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2 <= prod;
			c_s2 <= canvas_s1;
		end
		if (en.s3) begin
			q_s3 <= num[31:16];
		end
		if (en.s4) begin
			res_s4 <= keep_s3 ? recip[30:23] : 8'd0;
		end
	end

endmodule

[rtl/core/masked_alpha_blend_clipped.sv]
// Masked alpha blend of fragment pixels into a canvas, with clipping.
// The input channel (in_valid/in_ready) carries one fragment pixel per
// transfer: its position in the fragment, its colour, a Q1.16 mask and the
// canvas colour at the mapped location. The output channel (out_valid and
// out_ready) returns one result per input in order: a write flag, the canvas
// address and the blended colour, all zero when the pixel is clipped or
// skipped. Registers are written through the cfg channel, which is always
// ready; they should only change while no pixel is in flight.
// Each input is registered in s1 and its result is driven from s4. A new
// pixel can be taken every cycle while the receiver accepts results, through
// the four-stage pipeline, whose stages hold the mask product, the address
// and blend multiplies, the blend sum and the reciprocal divide by 255
// respectively.
// When the receiver stalls, the pipeline compacts its bubbles and in_ready
// falls only once all four stages hold pixels. Reset empties the pipeline
// and restores the register defaults (zero origin and size, threshold 65).
module masked_alpha_blend_clipped (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [12:0] frag_col,
	input  logic [12:0] frag_row,
	input  logic [16:0] mask_level,
	input  logic [7:0]  frag_red,
	input  logic [7:0]  frag_green,
	input  logic [7:0]  frag_blue,
	input  logic [7:0]  frag_opacity,
	input  logic [7:0]  canvas_red,
	input  logic [7:0]  canvas_green,
	input  logic [7:0]  canvas_blue,
	input  logic [7:0]  canvas_alpha,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [25:0] canvas_addr,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	mabc_pkg::cfg_t      cfg;
	mabc_pkg::stage_en_t en;
	logic                en1;
	logic                v1_s1, v2_s2, v3_s3, v4_s4;

	logic signed [15:0]  cx_s1, cy_s1;
	logic                mask_skip_s1;
	logic [23:0]         n_s1;
	logic [7:0]          fr_s1, fg_s1, fb_s1, fa_s1;
	logic [7:0]          cr_s1, cg_s1, cb_s1, ca_s1;

	logic                write_s2;
	logic [26:0]         row_s2;
	logic [12:0]         cx_s2;
	logic                write_s3;
	logic [25:0]         addr_s3;
	logic [25:0]         addr_s4;
	logic                write_s4;

	logic signed [15:0]  cx_next, cy_next;
	logic [16:0]         mask_sat;
	logic [24:0]         n_full;
	logic                in_canvas;
	logic [26:0]         addr_sum;

	mabc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en.s4    = !v4_s4 || out_ready;
	assign en.s3    = !v3_s3 || en.s4;
	assign en.s2    = !v2_s2 || en.s3;
	assign en1      = !v1_s1 || en.s2;
	assign in_ready = en1;

	assign cx_next  = $signed({3'b000, frag_col}) + 16'(cfg.origin_x);
	assign cy_next  = $signed({3'b000, frag_row}) + 16'(cfg.origin_y);
	assign mask_sat = (mask_level > mabc_pkg::MASK_FULL) ? mabc_pkg::MASK_FULL : mask_level;
	assign n_full   = mask_sat * frag_opacity;

	assign in_canvas = !cx_s1[15] && !cy_s1[15]
		&& ({1'b0, cx_s1[14:0]} < {2'b00, cfg.width})
		&& ({1'b0, cy_s1[14:0]} < {2'b00, cfg.height});
	assign addr_sum = row_s2 + {14'd0, cx_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1 <= in_valid;
			end
			if (en.s2) begin
				v2_s2 <= v1_s1;
			end
			if (en.s3) begin
				v3_s3 <= v2_s2;
			end
			if (en.s4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1        <= cx_next;
			cy_s1        <= cy_next;
			mask_skip_s1 <= mask_sat <= cfg.thr;
			n_s1         <= n_full[23:0];
			fr_s1        <= frag_red;
			fg_s1        <= frag_green;
			fb_s1        <= frag_blue;
			fa_s1        <= frag_opacity;
			cr_s1        <= canvas_red;
			cg_s1        <= canvas_green;
			cb_s1        <= canvas_blue;
			ca_s1        <= canvas_alpha;
		end
		if (en.s2) begin
			write_s2 <= in_canvas && !mask_skip_s1 && ({1'b0, n_s1} > cfg.thr255);
			row_s2   <= cy_s1[12:0] * cfg.width;
			cx_s2    <= cx_s1[12:0];
		end
		if (en.s3) begin
			write_s3 <= write_s2;
			addr_s3  <= addr_sum[25:0];
		end
		if (en.s4) begin
			write_s4 <= write_s3;
			addr_s4  <= write_s3 ? addr_s3 : 26'd0;
		end
	end

	mabc_lerp u_lerp_red (
		.clk (clk), .en (en), .n_s1 (n_s1), .canvas_s1 (cr_s1), .frag_s1 (fr_s1),
		.keep_s3 (write_s3), .res_s4 (out_red)
	);

	mabc_lerp u_lerp_green (
		.clk (clk), .en (en), .n_s1 (n_s1), .canvas_s1 (cg_s1), .frag_s1 (fg_s1),
		.keep_s3 (write_s3), .res_s4 (out_green)
	);

	mabc_lerp u_lerp_blue (
		.clk (clk), .en (en), .n_s1 (n_s1), .canvas_s1 (cb_s1), .frag_s1 (fb_s1),
		.keep_s3 (write_s3), .res_s4 (out_blue)
	);

	mabc_lerp u_lerp_alpha (
		.clk (clk), .en (en), .n_s1 (n_s1), .canvas_s1 (ca_s1), .frag_s1 (fa_s1),
		.keep_s3 (write_s3), .res_s4 (out_alpha)
	);

	assign out_valid    = v4_s4;
	assign write_enable = write_s4;
	assign canvas_addr  = addr_s4;

	// A skipped or clipped pixel leaves every result field at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> canvas_addr == 26'd0 && out_red == 8'd0
			&& out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0)
	else $error("skipped pixel carries non-zero result");

	// Input is refused only when every stage holds a pixel and the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v1_s1 && v2_s2 && v3_s3 && out_valid && !out_ready)
	else $error("pipeline refuses input while a stage is empty");

	// A written pixel always addresses the inside of the canvas.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable
			|-> {1'b0, canvas_addr} < (27'(cfg.width) * 27'(cfg.height)))
	else $error("write address lies outside the canvas");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int PIPE_DEPTH = 4;
	localparam int RESET_ROWS = 3;
	localparam longint unsigned BLEND_SCALE = 64'd255 * 64'd65536;

	typedef struct packed {
		logic [12:0] col;
		logic [12:0] row;
		logic [16:0] mask;
		logic [7:0]  fr;
		logic [7:0]  fg;
		logic [7:0]  fb;
		logic [7:0]  fa;
		logic [7:0]  cr;
		logic [7:0]  cg;
		logic [7:0]  cb;
		logic [7:0]  ca;
	} pixel_t;

	typedef struct packed {
		logic        we;
		logic [25:0] addr;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} blend_t;

	typedef struct packed {
		pixel_t px;
		logic   typed;
		blend_t res;
	} dir_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [12:0] frag_col;
	logic [12:0] frag_row;
	logic [16:0] mask_level;
	logic [7:0]  frag_red;
	logic [7:0]  frag_green;
	logic [7:0]  frag_blue;
	logic [7:0]  frag_opacity;
	logic [7:0]  canvas_red;
	logic [7:0]  canvas_green;
	logic [7:0]  canvas_blue;
	logic [7:0]  canvas_alpha;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        write_enable;
	logic [25:0] canvas_addr;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;

	logic signed [14:0] cfg_ox = '0;
	logic signed [14:0] cfg_oy = '0;
	logic [13:0]        cfg_w = '0;
	logic [13:0]        cfg_h = '0;
	logic [16:0]        cfg_thr = mabc_pkg::THRESHOLD_RST;

	blend_t   pending_blends[$];
	dir_row_t dir_rows[$];
	int       mismatch_count = 0;
	int       burst_left = 0;

	rx_mode_t   rx_mode = RX_FREE;
	int         rx_left = 0;
	logic [3:0] rx_tick = '0;

	int phase_cfg[7][6] = '{
		'{0, 0, 64, 48, 65, 200},
		'{-8192, -8192, 8192, 8192, 0, 40},
		'{16383, -16384, 16383, 16383, 131071, 30},
		'{-100, 50, 16383, 9000, 0, 200},
		'{37, -13, 1, 1, 65536, 40},
		'{-8000, -4000, 300, 4192, 1000, 150},
		'{5, 7, 333, 17, 40000, 150}
	};

	masked_alpha_blend_clipped dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frag_col(frag_col),
		.frag_row(frag_row),
		.mask_level(mask_level),
		.frag_red(frag_red),
		.frag_green(frag_green),
		.frag_blue(frag_blue),
		.frag_opacity(frag_opacity),
		.canvas_red(canvas_red),
		.canvas_green(canvas_green),
		.canvas_blue(canvas_blue),
		.canvas_alpha(canvas_alpha),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_enable(write_enable),
		.canvas_addr(canvas_addr),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic pixel_t mk_pixel(input int col, row, mask, fr, fg, fb, fa,
			cr, cg, cb, ca);
		pixel_t p;
		p.col = col[12:0];
		p.row = row[12:0];
		p.mask = mask[16:0];
		p.fr = fr[7:0];
		p.fg = fg[7:0];
		p.fb = fb[7:0];
		p.fa = fa[7:0];
		p.cr = cr[7:0];
		p.cg = cg[7:0];
		p.cb = cb[7:0];
		p.ca = ca[7:0];
		return p;
	endfunction

	function automatic blend_t mk_blend(input int we, addr, red, green, blue, alpha);
		blend_t b;
		b.we = we[0];
		b.addr = addr[25:0];
		b.red = red[7:0];
		b.green = green[7:0];
		b.blue = blue[7:0];
		b.alpha = alpha[7:0];
		return b;
	endfunction

	function automatic logic [7:0] lerp8(input logic [7:0] dst, input logic [7:0] src,
			input longint unsigned weight);
		longint unsigned acc;
		acc = (BLEND_SCALE - weight) * dst + weight * src;
		return 8'(acc / BLEND_SCALE);
	endfunction

	// Pixels outside the canvas or at or below the threshold leave every field at zero.
	function automatic blend_t blend_pixel(input pixel_t p);
		blend_t r;
		int cx, cy, w, h;
		longint unsigned m, weight;
		r = '0;
		w = (cfg_w > mabc_pkg::MAX_DIM) ? mabc_pkg::MAX_DIM : int'(cfg_w);
		h = (cfg_h > mabc_pkg::MAX_DIM) ? mabc_pkg::MAX_DIM : int'(cfg_h);
		cx = int'(p.col) + int'(cfg_ox);
		cy = int'(p.row) + int'(cfg_oy);
		m = (p.mask > mabc_pkg::MASK_FULL) ? mabc_pkg::MASK_FULL : p.mask;
		if (cx < 0 || cy < 0 || cx >= w || cy >= h)
			return r;
		if (m <= cfg_thr)
			return r;
		weight = m * p.fa;
		if (weight <= 64'd255 * cfg_thr)
			return r;
		r.we = 1'b1;
		r.addr = 26'(cy * w + cx);
		r.red = lerp8(p.cr, p.fr, weight);
		r.green = lerp8(p.cg, p.fg, weight);
		r.blue = lerp8(p.cb, p.fb, weight);
		r.alpha = lerp8(p.ca, p.fa, weight);
		return r;
	endfunction

	function automatic pixel_t random_pixel();
		int w, h, ox, oy, col, row, cx, cy, m, a;
		w = (cfg_w > mabc_pkg::MAX_DIM) ? mabc_pkg::MAX_DIM : int'(cfg_w);
		h = (cfg_h > mabc_pkg::MAX_DIM) ? mabc_pkg::MAX_DIM : int'(cfg_h);
		ox = cfg_ox;
		oy = cfg_oy;
		col = $urandom_range(0, 8191);
		row = $urandom_range(0, 8191);
		if (w > 0 && $urandom_range(0, 3) != 0) begin
			cx = int'($urandom_range(0, w + 3)) - 2;
			if (cx - ox >= 0 && cx - ox <= 8191)
				col = cx - ox;
		end
		if (h > 0 && $urandom_range(0, 3) != 0) begin
			cy = int'($urandom_range(0, h + 3)) - 2;
			if (cy - oy >= 0 && cy - oy <= 8191)
				row = cy - oy;
		end
		case ($urandom_range(0, 7))
			0: m = 0;
			1: m = mabc_pkg::MASK_FULL;
			2: m = $urandom_range(65537, 131071);
			3: begin
				m = int'(cfg_thr) + int'($urandom_range(0, 4)) - 2;
				if (m < 0)
					m = 0;
				if (m > 131071)
					m = 131071;
			end
			default: m = $urandom_range(0, 65536);
		endcase
		case ($urandom_range(0, 5))
			0: a = 0;
			1: a = 255;
			default: a = $urandom_range(0, 255);
		endcase
		return mk_pixel(col, row, m, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), a, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			mabc_pkg::REG_ORIGIN_X: cfg_ox = val[14:0];
			mabc_pkg::REG_ORIGIN_Y: cfg_oy = val[14:0];
			mabc_pkg::REG_CANVAS_WIDTH: cfg_w = val[13:0];
			mabc_pkg::REG_CANVAS_HEIGHT: cfg_h = val[13:0];
			mabc_pkg::REG_SKIP_THRESHOLD: cfg_thr = val[16:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int ox, oy, w, h, thr);
		write_reg(mabc_pkg::REG_ORIGIN_X, ox & 32'h7FFF);
		write_reg(mabc_pkg::REG_ORIGIN_Y, oy & 32'h7FFF);
		write_reg(mabc_pkg::REG_CANVAS_WIDTH, w & 32'h3FFF);
		write_reg(mabc_pkg::REG_CANVAS_HEIGHT, h & 32'h3FFF);
		write_reg(mabc_pkg::REG_SKIP_THRESHOLD, thr & 32'h1FFFF);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input pixel_t px, input logic typed, input blend_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		frag_col <= px.col;
		frag_row <= px.row;
		mask_level <= px.mask;
		frag_red <= px.fr;
		frag_green <= px.fg;
		frag_blue <= px.fb;
		frag_opacity <= px.fa;
		canvas_red <= px.cr;
		canvas_green <= px.cg;
		canvas_blue <= px.cb;
		canvas_alpha <= px.ca;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_blends.push_back(typed ? want : blend_pixel(px));
		burst_left--;
	endtask

	// Called in the step of the last input transfer, so in_valid is assigned once there.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_blends.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input blend_t want, input blend_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: exp %0b %0d %0d/%0d/%0d/%0d got %0b %0d %0d/%0d/%0d/%0d",
				$time, what, want.we, want.addr, want.red, want.green, want.blue,
				want.alpha, got.we, got.addr, got.red, got.green, got.blue, got.alpha);
	endtask

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (rx_tick[2:0] != 3'd3) && (rx_tick[2:0] != 3'd4);
		endcase
	end

	always @(posedge clk) begin
		blend_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {write_enable, canvas_addr, out_red, out_green, out_blue, out_alpha};
			if (pending_blends.size() == 0) begin
				note_mismatch("result transfer with nothing pending", '0, got);
			end else begin
				want = pending_blends.pop_front();
				if (got.we !== want.we || got.addr !== want.addr || got.red !== want.red
						|| got.green !== want.green || got.blue !== want.blue
						|| got.alpha !== want.alpha)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	initial begin
		int ox, oy, w, h, thr, n_items;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= mabc_pkg::REG_ORIGIN_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		frag_col <= '0;
		frag_row <= '0;
		mask_level <= '0;
		frag_red <= '0;
		frag_green <= '0;
		frag_blue <= '0;
		frag_opacity <= '0;
		canvas_red <= '0;
		canvas_green <= '0;
		canvas_blue <= '0;
		canvas_alpha <= '0;

		// A zero-sized canvas after reset clips everything.
		dir_rows.push_back({mk_pixel(0, 0, 65536, 255, 255, 255, 255, 255, 255, 255, 255),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(8191, 8191, 131071, 9, 8, 7, 255, 1, 2, 3, 4),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(12, 34, 40000, 100, 150, 200, 128, 50, 60, 70, 80),
			1'b1, blend_t'('0)});
		// Full canvas at zero origin, reset threshold.
		dir_rows.push_back({mk_pixel(5, 3, 65536, 10, 20, 30, 255, 200, 100, 50, 0),
			1'b1, mk_blend(1, 3 * 8192 + 5, 10, 20, 30, 255)});
		dir_rows.push_back({mk_pixel(0, 0, 0, 255, 255, 255, 255, 0, 0, 0, 0),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(1, 1, 65, 255, 255, 255, 255, 0, 0, 0, 0),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(2, 1, 66, 255, 255, 255, 255, 0, 0, 0, 0),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(3, 1, 65536, 255, 255, 255, 0, 0, 0, 0, 0),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(8191, 8191, 131071, 255, 0, 255, 255, 0, 255, 0, 0),
			1'b1, mk_blend(1, 67108863, 255, 0, 255, 255)});
		dir_rows.push_back({mk_pixel(100, 200, 65537, 17, 99, 240, 128, 255, 3, 60, 77),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(7, 9, 32768, 255, 255, 255, 255, 0, 0, 0, 0),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(8191, 0, 40000, 0, 128, 255, 200, 255, 128, 0, 33),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(0, 8191, 65535, 1, 254, 127, 254, 254, 1, 128, 2),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(4, 4, 1, 255, 255, 255, 255, 0, 0, 0, 0),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(6, 6, 131071, 0, 0, 0, 0, 255, 255, 255, 255),
			1'b1, blend_t'('0)});
		dir_rows.push_back({mk_pixel(8, 8, 66, 200, 10, 90, 254, 5, 250, 45, 100),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(9, 9, 100, 200, 10, 90, 166, 5, 250, 45, 100),
			1'b0, blend_t'('0)});
		dir_rows.push_back({mk_pixel(10, 9, 100, 200, 10, 90, 165, 5, 250, 45, 100),
			1'b1, blend_t'('0)});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (i == RESET_ROWS) begin
				settle();
				configure(0, 0, mabc_pkg::MAX_DIM, mabc_pkg::MAX_DIM,
					mabc_pkg::THRESHOLD_RST);
			end
			push_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].res);
		end
		settle();

		for (int ph = 0; ph < 13; ph++) begin
			if (ph < 7) begin
				ox = phase_cfg[ph][0];
				oy = phase_cfg[ph][1];
				w = phase_cfg[ph][2];
				h = phase_cfg[ph][3];
				thr = phase_cfg[ph][4];
				n_items = phase_cfg[ph][5];
			end else begin
				ox = int'($urandom_range(0, 400)) - 200;
				oy = int'($urandom_range(0, 400)) - 200;
				w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
					: $urandom_range(1, 600);
				h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
					: $urandom_range(1, 600);
				case ($urandom_range(0, 3))
					0: thr = $urandom_range(0, 100);
					1: thr = $urandom_range(0, 4000);
					2: thr = $urandom_range(0, 65536);
					default: thr = $urandom_range(0, 131071);
				endcase
				n_items = 130;
			end
			configure(ox, oy, w, h, thr);
			for (int i = 0; i < n_items; i++) begin
				// Hold off mid-phase until the pipeline has emptied completely.
				if (i == n_items / 2)
					settle();
				push_pixel(random_pixel(), 1'b0, blend_t'('0));
			end
			settle();
		end

		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_blends.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/mabc_pkg.sv
rtl/core/mabc_cfg.sv
rtl/core/mabc_lerp.sv
rtl/core/masked_alpha_blend_clipped.sv
verif/tb_top.sv
